// ===== sv/shift_cut_controller_defines.svh =====
// Assertion macros shared by the shift cut controller checker.
// Depends on nothing; included by the files that carry assertions.
`ifndef SHIFT_CUT_CONTROLLER_DEFINES_SVH
`define SHIFT_CUT_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("shift cut controller check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("shift cut controller check failed");

`endif

// ===== sv/scc_pkg.sv =====
// Shared types, constants and helpers of the shift cut controller.
// Depends on nothing; imported by the top level, controller, datapath and divider.
package scc_pkg;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 60;
  localparam int KILL_TIME_W = 10;
  localparam int PROD_W      = 24;
  localparam int DIV_STEPS   = PROD_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_KILL_TIME_TABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PRESS_TICKS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REARM_DELAY     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_DIVIDER    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FUEL_CUT_ENABLE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IGN_CUT_ENABLE  = 3'd5;

  // Reset values of the registers.
  localparam logic [59:0] RST_KILL_TIME_TABLE = 60'd73255032061018625;
  localparam logic [15:0] RST_MIN_PRESS_TICKS = 16'd5;
  localparam logic [15:0] RST_REARM_DELAY     = 16'd500;
  localparam logic [15:0] RST_TIME_DIVIDER    = 16'd2560;

  localparam logic [13:0] PRESS_LEVEL = 14'd64;
  localparam logic [15:0] MIN_SPEED   = 16'd5120;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_COMMIT
  } scc_state_e;

  typedef struct packed {
    logic load_in;
    logic load_prod;
    logic start_div;
    logic commit;
  } scc_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_free;
  } scc_status_t;

  // Kill time of a gear; gears outside one to five use the sixth slot.
  function automatic logic [KILL_TIME_W-1:0] gear_time(input logic [59:0] tbl,
                                                      input logic [7:0]  gear);
    logic [2:0] slot;
    if (gear inside {[8'd1:8'd5]}) begin
      slot = 3'(gear - 8'd1);
    end else begin
      slot = 3'd5;
    end
    return tbl[slot*KILL_TIME_W +: KILL_TIME_W];
  endfunction

endpackage

// ===== sv/scc_if.sv =====
// Valid/ready channel interfaces for the shift cut controller.
// Depends on nothing; used by the top level and its environment.
interface scc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] shifter_level;
  logic [15:0] engine_speed;
  logic [7:0]  gear_position;

  modport source (output valid, shifter_level, engine_speed, gear_position,
                  input ready);
  modport sink   (input valid, shifter_level, engine_speed, gear_position,
                  output ready);
endinterface

interface scc_out_if;
  logic valid;
  logic ready;
  logic fuel_cut;
  logic ign_cut;
  logic kill_on;

  modport source (output valid, fuel_cut, ign_cut, kill_on, input ready);
  modport sink   (input valid, fuel_cut, ign_cut, kill_on, output ready);
endinterface

// ===== sv/shift_cut_controller.sv =====
// Top level of the quick-shifter cut controller.
// Depends on scc_pkg, scc_if, scc_ctrl and scc_datapath.
//
//   channel  | direction | transaction carries
//   ---------+-----------+----------------------------------------------
//   in_ch    | sink      | shifter_level, engine_speed, gear_position
//   out_ch   | source    | fuel_cut, ign_cut, kill_on
//   cfg      | write     | cfg_we_i, cfg_idx_i, cfg_data_i
//
// A tick goes through ST_PREP to ST_COMMIT when the shifter is released
// or the engine is slow, and through ST_DIV_START and ST_DIV_WAIT when
// the 24-step restoring divider computes a new kill length. Reset is
// asynchronous and active low and restores all but the input, product,
// divider and result data registers. A result waits in an output
// register, so a stalled sink only holds up the next tick, at commit.
module shift_cut_controller (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  scc_in_if.sink                         in_ch,
  scc_out_if.source                      out_ch,
  input  logic                           cfg_we_i,
  input  logic [scc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [scc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import scc_pkg::*;

  scc_cmd_t    cmd;
  scc_status_t status;
  logic        in_ready;

  // The controller owns the input handshake and the step sequence.
  scc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds configuration, tick state and the result register.
  scc_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .shifter_level_i (in_ch.shifter_level),
    .engine_speed_i  (in_ch.engine_speed),
    .gear_position_i (in_ch.gear_position),
    .out_ready_i     (out_ch.ready),
    .out_valid_o     (out_ch.valid),
    .fuel_cut_o      (out_ch.fuel_cut),
    .ign_cut_o       (out_ch.ign_cut),
    .kill_on_o       (out_ch.kill_on)
  );

  assign in_ch.ready = in_ready;
endmodule

// ===== sv/scc_divider.sv =====
// Restoring divider, one quotient bit per cycle, for the kill length.
// Depends on scc_pkg.
module scc_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [scc_pkg::PROD_W-1:0]  dividend_i,
  input  logic [15:0]                 divisor_i,
  output logic                        done_o,
  output logic [scc_pkg::PROD_W-1:0]  quotient_o
);
  import scc_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [15:0]          rem_q, rem_d;
  logic [PROD_W-1:0]    quo_q;
  logic [16:0]          trial;
  logic                 qbit;

  // A zero divisor yields an all-ones quotient, which saturates later.
  always_comb begin
    trial = {rem_q, quo_q[PROD_W-1]};
    if (trial >= {1'b0, divisor_i}) begin
      qbit  = 1'b1;
      rem_d = 16'(trial - {1'b0, divisor_i});
    end else begin
      qbit  = 1'b0;
      rem_d = trial[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[PROD_W-2:0], qbit};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
endmodule

// ===== sv/scc_datapath.sv =====
// Datapath: configuration registers, tick state, kill length and result register.
// Depends on scc_pkg and scc_divider.
module scc_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  scc_pkg::scc_cmd_t              cmd_i,
  output scc_pkg::scc_status_t           status_o,
  input  logic                           cfg_we_i,
  input  logic [scc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [scc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [15:0]                    shifter_level_i,
  input  logic [15:0]                    engine_speed_i,
  input  logic [7:0]                     gear_position_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic                           fuel_cut_o,
  output logic                           ign_cut_o,
  output logic                           kill_on_o
);
  import scc_pkg::*;

  logic [59:0] kill_table_q;
  logic [15:0] min_press_q, rearm_q, divider_q;
  logic        fuel_en_q, ign_en_q;

  logic [15:0] level_q, speed_q;
  logic [7:0]  gear_in_q;
  logic [PROD_W-1:0] prod_q;

  logic        armed_q, armed_d;
  logic        kill_q, kill_d;
  logic [15:0] phase_q, phase_d;
  logic [15:0] press_q, press_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  gear_lat_q, gear_lat_d;

  logic        out_valid_q;
  logic        fuel_q, ign_q, kill_out_q;

  logic              pressed, fast, div_done;
  logic [PROD_W-1:0] quotient;
  logic [15:0]       len_sat;

  scc_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.start_div),
    .dividend_i (prod_q),
    .divisor_i  (divider_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kill_table_q <= RST_KILL_TIME_TABLE;
      min_press_q  <= RST_MIN_PRESS_TICKS;
      rearm_q      <= RST_REARM_DELAY;
      divider_q    <= RST_TIME_DIVIDER;
      fuel_en_q    <= 1'b1;
      ign_en_q     <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_KILL_TIME_TABLE: kill_table_q <= cfg_data_i[59:0];
        CFG_MIN_PRESS_TICKS: min_press_q  <= cfg_data_i[15:0];
        CFG_REARM_DELAY:     rearm_q      <= cfg_data_i[15:0];
        CFG_TIME_DIVIDER:    divider_q    <= cfg_data_i[15:0];
        CFG_FUEL_CUT_ENABLE: fuel_en_q    <= cfg_data_i[0];
        CFG_IGN_CUT_ENABLE:  ign_en_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      level_q   <= shifter_level_i;
      speed_q   <= engine_speed_i;
      gear_in_q <= gear_position_i;
    end
    if (cmd_i.load_prod) begin
      prod_q <= {14'd0, gear_time(kill_table_q, gear_lat_q)} * {10'd0, speed_q[15:2]};
    end
  end

  assign pressed = (level_q[15:2] <= PRESS_LEVEL);
  assign fast    = (speed_q > MIN_SPEED);
  assign len_sat = (quotient[PROD_W-1:16] != '0) ? 16'hFFFF : quotient[15:0];

  always_comb begin
    armed_d    = armed_q;
    len_d      = len_q;
    kill_d     = kill_q;
    phase_d    = phase_q;
    press_d    = press_q;
    gear_lat_d = gear_lat_q;
    if (pressed) begin
      if (fast) begin
        armed_d = 1'b1;
        len_d   = len_sat;
      end
    end else begin
      armed_d = 1'b0;
    end
    if (kill_q) begin
      phase_d = phase_q + 16'd1;
      if (phase_d >= len_d) begin
        kill_d  = 1'b0;
        phase_d = rearm_q;
      end
    end else if (phase_q != 16'd0) begin
      if (!armed_d) begin
        phase_d = phase_q - 16'd1;
      end
    end else if (armed_d) begin
      press_d = press_q + 16'd1;
      if (press_d >= min_press_q) begin
        kill_d  = 1'b1;
        phase_d = 16'd0;
      end
    end else begin
      press_d    = 16'd0;
      gear_lat_d = gear_in_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q    <= 1'b0;
      kill_q     <= 1'b0;
      phase_q    <= RST_REARM_DELAY;
      press_q    <= 16'd0;
      len_q      <= 16'd0;
      gear_lat_q <= 8'd0;
    end else if (cmd_i.commit) begin
      armed_q    <= armed_d;
      kill_q     <= kill_d;
      phase_q    <= phase_d;
      press_q    <= press_d;
      len_q      <= len_d;
      gear_lat_q <= gear_lat_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      fuel_q     <= kill_d & fuel_en_q;
      ign_q      <= kill_d & ign_en_q;
      kill_out_q <= kill_d;
    end
  end

  assign status_o.need_div = pressed & fast;
  assign status_o.div_done = div_done;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign fuel_cut_o  = fuel_q;
  assign ign_cut_o   = ign_q;
  assign kill_on_o   = kill_out_q;
endmodule

// ===== sv/scc_ctrl.sv =====
// Controller state machine that sequences one tick through the datapath.
// Depends on scc_pkg.
module scc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  scc_pkg::scc_status_t status_i,
  output scc_pkg::scc_cmd_t    cmd_o
);
  import scc_pkg::*;

  scc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_PREP;
      end
      ST_PREP: begin
        state_d = status_i.need_div ? ST_DIV_START : ST_COMMIT;
      end
      ST_DIV_START: begin
        state_d = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (status_i.div_done) state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      ST_PREP: begin
        cmd_o.load_prod = 1'b1;
      end
      ST_DIV_START: begin
        cmd_o.start_div = 1'b1;
      end
      ST_DIV_WAIT: ;
      ST_COMMIT: begin
        cmd_o.commit = status_i.out_free;
      end
      default: ;
    endcase
  end
endmodule

// ===== sv/scc_checker.sv =====
// Port-level checks of the shift cut controller, bound to the top level.
// Depends on shift_cut_controller_defines.svh.
`include "shift_cut_controller_defines.svh"

module scc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic fuel_cut_i,
  input logic ign_cut_i,
  input logic kill_on_i
);
  // One tick is worked on at a time, so acceptance closes the input.
  `SCC_ASSERT_NEXT(a_one_tick, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)

  // A waiting result keeps its value until it is taken.
  `SCC_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable({fuel_cut_i, ign_cut_i, kill_on_i}))

  // No cut request is issued outside the kill phase.
  `SCC_ASSERT_IMPL(a_cut_in_kill, clk_i, rst_ni, out_valid_i && (fuel_cut_i || ign_cut_i), kill_on_i)
endmodule

bind shift_cut_controller scc_checker u_scc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch.valid),
  .in_ready_i  (in_ch.ready),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .fuel_cut_i  (out_ch.fuel_cut),
  .ign_cut_i   (out_ch.ign_cut),
  .kill_on_i   (out_ch.kill_on)
);
